/* src/hgn_pkg.sv */
// Shared types, constants and register codes of the hex-grid normal block.
`default_nettype none
package hgn_pkg;

  localparam int unsigned DEF_MAX_ROW_LENGTH = 1024;
  localparam int unsigned DEF_HEIGHT_BITS    = 16;

  // Widest column index the command record carries (row length up to 4096).
  localparam int unsigned COL_W = 12;

  typedef enum logic [1:0] {
    REG_ROW_LENGTH   = 2'd0,
    REG_ROW_TOTAL    = 2'd1,
    REG_CELL_SPACING = 2'd2
  } reg_index_t;

  localparam logic [10:0] RST_ROW_LENGTH   = 11'd1024;
  localparam logic [15:0] RST_ROW_TOTAL    = 16'd1024;
  localparam logic [15:0] RST_CELL_SPACING = 16'd256;

  localparam logic MODE_SAMPLE = 1'b0;
  localparam logic MODE_FLUSH  = 1'b1;

  // Divisors: 6*cell for x, 2*sqrt3*cell (sqrt3 in unsigned Q1.16) for z.
  localparam int unsigned DENX_K = 6;
  localparam int unsigned DENZ_K = 2 * 113512;
  localparam int unsigned DENX_W = 19;
  localparam int unsigned DENZ_W = 34;

  typedef struct packed {
    logic [COL_W-1:0] x;
    logic [15:0]      z;
    logic [1:0]       bank;
    logic             below;
    logic             fend;
    logic             run_end;
  } cmd_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_GATHER,
    BK_CALC,
    BK_DIVIDE,
    BK_HOLD
  } back_state_t;

endpackage
`default_nettype wire

/* src/hgn_if.sv */
// Handshake channels for altitude samples and normal results.
`default_nettype none
interface hgn_in_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [15:0] altitude;
  modport source (output valid, mode, altitude, input ready);
  modport sink (input valid, mode, altitude, output ready);
endinterface

interface hgn_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] normal_x;
  logic [15:0] normal_z;
  logic [9:0]  vertex_column;
  logic [15:0] vertex_row;
  logic        run_end;
  logic        frame_end;
  modport source (output valid, normal_x, normal_z, vertex_column, vertex_row, run_end,
                  frame_end, input ready);
  modport sink (input valid, normal_x, normal_z, vertex_column, vertex_row, run_end,
                frame_end, output ready);
endinterface
`default_nettype wire

/* src/hgn_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module hgn_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 3072
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

/* src/hgn_front.sv */
// Front end: accepts samples and flush ticks, writes the line store, issues vertex commands.
`default_nettype none
module hgn_front import hgn_pkg::*; #(
  parameter int unsigned MAX_ROW_LENGTH = DEF_MAX_ROW_LENGTH,
  parameter int unsigned HEIGHT_BITS    = DEF_HEIGHT_BITS,
  localparam int unsigned CW = $clog2(MAX_ROW_LENGTH),
  localparam int unsigned LW = $clog2(MAX_ROW_LENGTH + 1),
  localparam int unsigned AW = $clog2(3 * MAX_ROW_LENGTH),
  localparam int unsigned SW = (HEIGHT_BITS < 16) ? HEIGHT_BITS : 16
) (
  input  logic          clk,
  input  logic          rst,
  hgn_in_if.sink        samples,
  input  logic          shape_write,
  input  logic [LW-1:0] len,
  input  logic [15:0]   rows,
  input  logic          q_empty,
  input  logic          back_busy,
  output logic          mem_we,
  output logic [AW-1:0] mem_waddr,
  output logic [SW-1:0] mem_wdata,
  output logic [1:0]    push_n,
  output cmd_t          push0,
  output cmd_t          push1
);
  logic [CW-1:0] in_column, in_column_next;
  logic [15:0]   in_row, in_row_next;
  logic [1:0]    in_bank, in_bank_next;
  logic [CW-1:0] flush_column, flush_column_next;

  logic          acc, is_sample, live, last_col, last_flush, emit_a, emit_b;
  logic [1:0]    vbank;
  cmd_t          cmd_a, cmd_b, cmd_f;

  assign samples.ready = q_empty && !back_busy;
  assign acc        = samples.valid && samples.ready;
  assign is_sample  = (samples.mode == MODE_SAMPLE);
  assign live       = (in_row < rows);
  assign last_col   = (LW'(in_column) + LW'(1) == len);
  assign last_flush = (LW'(flush_column) + LW'(1) >= len);
  assign vbank      = (in_bank == 2'd0) ? 2'd2 : in_bank - 2'd1;
  assign emit_a     = (in_row != 16'd0) && (in_column != '0);
  assign emit_b     = (in_row != 16'd0) && last_col;

  assign mem_we    = acc && is_sample && live;
  assign mem_waddr = AW'(in_bank) * AW'(MAX_ROW_LENGTH) + AW'(in_column);
  assign mem_wdata = samples.altitude[SW-1:0];

  always_comb begin
    cmd_a         = '0;
    cmd_a.x       = COL_W'(in_column - CW'(1));
    cmd_a.z       = in_row - 16'd1;
    cmd_a.bank    = vbank;
    cmd_a.below   = 1'b1;
    cmd_a.run_end = !emit_b;
    cmd_b         = cmd_a;
    cmd_b.x       = COL_W'(in_column);
    cmd_b.run_end = 1'b1;
    cmd_f         = '0;
    cmd_f.x       = COL_W'(flush_column);
    cmd_f.z       = rows - 16'd1;
    cmd_f.bank    = vbank;
    cmd_f.fend    = last_flush;
    cmd_f.run_end = 1'b1;
  end

  // Classify the transaction into zero, one or two vertex commands.
  always_comb begin
    push_n = 2'd0;
    push0  = cmd_a;
    push1  = cmd_b;
    if (acc && live && is_sample) begin
      if (emit_a && emit_b) begin
        push_n = 2'd2;
      end else if (emit_a) begin
        push_n = 2'd1;
      end else if (emit_b) begin
        push_n = 2'd1;
        push0  = cmd_b;
      end
    end else if (acc && !live && !is_sample) begin
      push_n = 2'd1;
      push0  = cmd_f;
    end
  end

  always_comb begin
    in_column_next    = in_column;
    in_row_next       = in_row;
    in_bank_next      = in_bank;
    flush_column_next = flush_column;
    priority if (shape_write) begin
      in_column_next    = '0;
      in_row_next       = '0;
      in_bank_next      = '0;
      flush_column_next = '0;
    end else if (acc && live && is_sample) begin
      if (last_col) begin
        in_column_next = '0;
        in_row_next    = in_row + 16'd1;
        in_bank_next   = (in_bank == 2'd2) ? 2'd0 : in_bank + 2'd1;
      end else begin
        in_column_next = in_column + CW'(1);
      end
    end else if (acc && !live && !is_sample) begin
      if (last_flush) begin
        in_column_next    = '0;
        in_row_next       = '0;
        in_bank_next      = '0;
        flush_column_next = '0;
      end else begin
        flush_column_next = flush_column + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_column    <= '0;
      in_row       <= '0;
      in_bank      <= '0;
      flush_column <= '0;
    end else begin
      in_column    <= in_column_next;
      in_row       <= in_row_next;
      in_bank      <= in_bank_next;
      flush_column <= flush_column_next;
    end
  end
endmodule
`default_nettype wire

/* src/hgn_queue.sv */
// Two-entry command queue between front and back end.
`default_nettype none
module hgn_queue import hgn_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic [1:0] push_n,
  input  cmd_t       push0,
  input  cmd_t       push1,
  input  logic       pop,
  output cmd_t       head,
  output logic       empty
);
  cmd_t       entries [2];
  cmd_t       entries_next [2];
  logic [1:0] count, count_next;

  assign head  = entries[0];
  assign empty = (count == 2'd0);

  always_comb begin
    entries_next = entries;
    count_next   = count;
    if (pop && count != 2'd0) begin
      entries_next[0] = entries[1];
      count_next      = count - 2'd1;
    end
    if (push_n != 2'd0 && count_next < 2'd2) begin
      entries_next[count_next[0]] = push0;
      count_next                  = count_next + 2'd1;
    end
    if (push_n == 2'd2 && count_next < 2'd2) begin
      entries_next[count_next[0]] = push1;
      count_next                  = count_next + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    entries <= entries_next;
    if (rst) begin
      count <= 2'd0;
    end else begin
      count <= count_next;
    end
  end
endmodule
`default_nettype wire

/* src/hgn_div.sv */
// Restoring divider, one quotient bit per cycle, 16-bit quotient with overflow flag.
`default_nettype none
module hgn_div #(
  parameter int unsigned NW = 33,
  parameter int unsigned DW = 19,
  localparam int unsigned RW = DW + 16,
  localparam int unsigned XW = (NW > RW) ? NW : RW
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [15:0]   quot,
  output logic          sat
);
  logic          running;
  logic [3:0]    cnt;
  logic [RW-1:0] rem, dsh;
  logic          ge;

  assign ge = (rem >= dsh);

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt     <= '0;
      end else if (running) begin
        cnt <= cnt + 4'd1;
        if (cnt == 4'd15) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sat  <= (XW'(num) >= XW'({den, 16'b0}));
      rem  <= RW'(num);
      dsh  <= RW'({den, 15'b0});
      quot <= '0;
    end else if (running) begin
      if (ge) begin
        rem <= rem - dsh;
      end
      quot <= {quot[14:0], ge};
      dsh  <= dsh >> 1;
    end
  end
endmodule
`default_nettype wire

/* src/hgn_back.sv */
// Back end: gathers the hex stencil from the line store, divides, rounds and saturates.
`default_nettype none
module hgn_back import hgn_pkg::*; #(
  parameter int unsigned MAX_ROW_LENGTH = DEF_MAX_ROW_LENGTH,
  parameter int unsigned HEIGHT_BITS    = DEF_HEIGHT_BITS,
  localparam int unsigned CW  = $clog2(MAX_ROW_LENGTH),
  localparam int unsigned LW  = $clog2(MAX_ROW_LENGTH + 1),
  localparam int unsigned AW  = $clog2(3 * MAX_ROW_LENGTH),
  localparam int unsigned SW  = (HEIGHT_BITS < 16) ? HEIGHT_BITS : 16,
  localparam int unsigned DXW = SW + 4,
  localparam int unsigned NXW = DXW + 13,
  localparam int unsigned NZW = DXW + 29
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_valid,
  input  cmd_t          q_head,
  output logic          pop,
  output logic          gathering,
  input  logic [LW-1:0] len,
  input  logic [15:0]   cell_len,
  output logic [AW-1:0] mem_raddr,
  input  logic [SW-1:0] mem_rdata,
  hgn_out_if.source     normals
);
  back_state_t state, state_next;
  cmd_t        cmd;
  logic [2:0]  g;
  logic signed [SW-1:0] nb [7];
  logic [DENX_W-1:0] den_x;
  logic [DENZ_W-1:0] den_z;
  logic        neg_x, neg_z;

  logic        start, load_out, done_x, done_z, sat_x, sat_z;
  logic [15:0] quot_x, quot_z;

  logic        ovalid, orun, ofend;
  logic [15:0] onx, onz, orow;
  logic [9:0]  ocol;

  logic [CW-1:0] x, xl, xr;
  logic          has_l, has_r, above, even;
  logic [1:0]    bup, bdn, rbank;
  logic [CW-1:0] rcol;
  logic [6:0]    use_nb;
  logic [2:0]    k;

  logic signed [DXW-1:0] dx, dz;
  logic [DXW-1:0]        mag_x, mag_z;
  logic [NXW-1:0]        num_x;
  logic [NZW-1:0]        num_z;

  function automatic logic [15:0] finish(input logic [15:0] q, input logic s, input logic n);
    if (n) begin
      if (s || q > 16'd32768) return 16'h8000;
      return 16'(16'd0 - q);
    end
    if (s || q > 16'd32767) return 16'h7FFF;
    return q;
  endfunction

  // Stencil addressing.
  assign x     = cmd.x[CW-1:0];
  assign xl    = x - CW'(1);
  assign xr    = x + CW'(1);
  assign has_l = (x != '0);
  assign has_r = (LW'(x) + LW'(1) < len);
  assign above = (cmd.z != 16'd0);
  assign even  = !cmd.z[0];
  assign bup   = (cmd.bank == 2'd0) ? 2'd2 : cmd.bank - 2'd1;
  assign bdn   = (cmd.bank == 2'd2) ? 2'd0 : cmd.bank + 2'd1;
  assign k     = g - 3'd1;

  assign use_nb[0] = 1'b1;
  assign use_nb[1] = has_l;
  assign use_nb[2] = has_r;
  assign use_nb[3] = even ? (has_l && above)     : above;
  assign use_nb[4] = even ? (has_l && cmd.below) : cmd.below;
  assign use_nb[5] = even ? above     : (has_r && above);
  assign use_nb[6] = even ? cmd.below : (has_r && cmd.below);

  always_comb begin
    rbank = cmd.bank;
    rcol  = x;
    unique case (g)
      3'd1: rcol = xl;
      3'd2: rcol = xr;
      3'd3: begin rbank = bup; rcol = even ? xl : x; end
      3'd4: begin rbank = bdn; rcol = even ? xl : x; end
      3'd5: begin rbank = bup; rcol = even ? x : xr; end
      3'd6: begin rbank = bdn; rcol = even ? x : xr; end
      default: begin rbank = cmd.bank; rcol = x; end
    endcase
  end
  assign mem_raddr = AW'(rbank) * AW'(MAX_ROW_LENGTH) + AW'(rcol);

  // Gradient sums: nb holds c, l, r, lu, ld, ru, rd.
  assign dx = (DXW'(nb[2]) <<< 1) + DXW'(nb[5]) + DXW'(nb[6])
            - (DXW'(nb[1]) <<< 1) - DXW'(nb[3]) - DXW'(nb[4]);
  assign dz = DXW'(nb[6]) + DXW'(nb[4]) - DXW'(nb[3]) - DXW'(nb[5]);
  assign mag_x = dx[DXW-1] ? DXW'(-dx) : DXW'(dx);
  assign mag_z = dz[DXW-1] ? DXW'(-dz) : DXW'(dz);
  assign num_x = NXW'({mag_x, 12'b0}) + NXW'(den_x >> 1);
  assign num_z = NZW'({mag_z, 28'b0}) + NZW'(den_z >> 1);

  hgn_div #(.NW(NXW), .DW(DENX_W)) u_div_x (
    .clk(clk), .rst(rst), .start(start), .num(num_x), .den(den_x),
    .done(done_x), .quot(quot_x), .sat(sat_x)
  );

  hgn_div #(.NW(NZW), .DW(DENZ_W)) u_div_z (
    .clk(clk), .rst(rst), .start(start), .num(num_z), .den(den_z),
    .done(done_z), .quot(quot_z), .sat(sat_z)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE:   if (q_valid) state_next = BK_GATHER;
      BK_GATHER: if (g == 3'd7) state_next = BK_CALC;
      BK_CALC:   state_next = BK_DIVIDE;
      BK_DIVIDE: if (done_x && done_z) state_next = BK_HOLD;
      BK_HOLD:   if (!ovalid || normals.ready) state_next = BK_IDLE;
      default:   state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    pop       = (state == BK_IDLE) && q_valid;
    gathering = (state == BK_GATHER);
    start     = (state == BK_CALC);
    load_out  = (state == BK_HOLD) && (!ovalid || normals.ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= BK_IDLE;
      ovalid <= 1'b0;
      g      <= '0;
    end else begin
      state <= state_next;
      if (load_out) begin
        ovalid <= 1'b1;
      end else if (normals.ready) begin
        ovalid <= 1'b0;
      end
      if (pop) begin
        g <= '0;
      end else if (gathering) begin
        g <= g + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cmd   <= q_head;
      den_x <= DENX_W'(DENX_K) * DENX_W'(cell_len == 16'd0 ? 16'd1 : cell_len);
      den_z <= DENZ_W'(DENZ_K) * DENZ_W'(cell_len == 16'd0 ? 16'd1 : cell_len);
    end
    if (gathering && g != 3'd0) begin
      if (k == 3'd0) begin
        nb[0] <= mem_rdata;
      end else begin
        nb[k] <= use_nb[k] ? mem_rdata : nb[0];
      end
    end
    if (start) begin
      neg_x <= (dx > 0);
      neg_z <= (dz > 0);
    end
    if (load_out) begin
      onx  <= finish(quot_x, sat_x, neg_x);
      onz  <= finish(quot_z, sat_z, neg_z);
      ocol <= 10'(x);
      orow <= cmd.z;
      orun <= cmd.run_end;
      ofend <= cmd.fend;
    end
  end

  assign normals.valid         = ovalid;
  assign normals.normal_x      = onx;
  assign normals.normal_z      = onz;
  assign normals.vertex_column = ocol;
  assign normals.vertex_row    = orow;
  assign normals.run_end       = orun;
  assign normals.frame_end     = ofend;
endmodule
`default_nettype wire

/* src/hex_grid_heightmap_normals.sv */
// Top level of the hex-grid heightmap normal block.
// Path of a normal from the transaction that causes it: the back end gathers
//   seven neighbors through the single line-store read port, forms the sums,
//   runs the two 16-step dividers, then loads the output register.
// New samples wait for an empty queue and an idle gather; the dividers may still run.
// Reset (rst, synchronous): clears frame counters and loads register defaults;
//   the line store is not cleared and holds no valid data until written.
`default_nettype none
module hex_grid_heightmap_normals import hgn_pkg::*; #(
  parameter int unsigned MAX_ROW_LENGTH = DEF_MAX_ROW_LENGTH,
  parameter int unsigned HEIGHT_BITS    = DEF_HEIGHT_BITS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        write_enable,
  input  logic [1:0]  write_index,
  input  logic [15:0] write_data,
  hgn_in_if.sink      samples,
  hgn_out_if.source   normals
);
  localparam int unsigned LW = $clog2(MAX_ROW_LENGTH + 1);
  localparam int unsigned AW = $clog2(3 * MAX_ROW_LENGTH);
  localparam int unsigned SW = (HEIGHT_BITS < 16) ? HEIGHT_BITS : 16;

  // Configuration registers.
  logic [10:0] row_length;
  logic [15:0] row_total;
  logic [15:0] cell_spacing;
  logic        shape_write;

  // Effective shape: row length clamped to [2, MAX_ROW_LENGTH], rows to at least 2.
  logic [LW-1:0] len;
  logic [15:0]   rows;

  logic          mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [SW-1:0] mem_wdata, mem_rdata;
  logic [1:0]    push_n;
  cmd_t          push0, push1, q_head;
  logic          q_empty, pop, gathering;

  // A write to row_length or row_total restarts the frame position.
  assign shape_write = write_enable &&
                       (write_index == REG_ROW_LENGTH || write_index == REG_ROW_TOTAL);

  always_ff @(posedge clk) begin
    if (rst) begin
      row_length   <= RST_ROW_LENGTH;
      row_total    <= RST_ROW_TOTAL;
      cell_spacing <= RST_CELL_SPACING;
    end else if (write_enable) begin
      unique case (write_index)
        REG_ROW_LENGTH:   row_length   <= write_data[10:0];
        REG_ROW_TOTAL:    row_total    <= write_data;
        REG_CELL_SPACING: cell_spacing <= write_data;
        default: ;  // drop writes to unknown indexes
      endcase
    end
  end

  always_comb begin
    if (row_length < 11'd2) begin
      len = LW'(2);
    end else if (32'(row_length) > 32'(MAX_ROW_LENGTH)) begin
      len = LW'(MAX_ROW_LENGTH);
    end else begin
      len = LW'(row_length);
    end
    rows = (row_total < 16'd2) ? 16'd2 : row_total;
  end

  // Front: hold new transactions while the back end still reads the line store
  // or commands are queued, so no write overtakes a pending stencil read.
  hgn_front #(.MAX_ROW_LENGTH(MAX_ROW_LENGTH), .HEIGHT_BITS(HEIGHT_BITS)) u_front (
    .clk(clk), .rst(rst), .samples(samples), .shape_write(shape_write),
    .len(len), .rows(rows), .q_empty(q_empty), .back_busy(gathering),
    .mem_we(mem_we), .mem_waddr(mem_waddr), .mem_wdata(mem_wdata),
    .push_n(push_n), .push0(push0), .push1(push1)
  );

  // Three rows of MAX_ROW_LENGTH heights, bank = row mod 3.
  hgn_ram #(.WIDTH(SW), .DEPTH(3 * MAX_ROW_LENGTH)) u_line_store (
    .clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
    .raddr(mem_raddr), .rdata(mem_rdata)
  );

  hgn_queue u_queue (
    .clk(clk), .rst(rst), .push_n(push_n), .push0(push0), .push1(push1),
    .pop(pop), .head(q_head), .empty(q_empty)
  );

  // Back: gather, divide, round and saturate; the output register lets the
  // front advance while a finished normal waits.
  hgn_back #(.MAX_ROW_LENGTH(MAX_ROW_LENGTH), .HEIGHT_BITS(HEIGHT_BITS)) u_back (
    .clk(clk), .rst(rst), .q_valid(!q_empty), .q_head(q_head), .pop(pop),
    .gathering(gathering), .len(len), .cell_len(cell_spacing),
    .mem_raddr(mem_raddr), .mem_rdata(mem_rdata), .normals(normals)
  );
endmodule
`default_nettype wire

/* src/hgn_checker.sv */
// Port-level checker for the hex-grid normal block, with its bind.
`default_nettype none
module hgn_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_normal_x,
  input logic [15:0] out_normal_z,
  input logic        out_run_end,
  input logic        out_frame_end
);
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_normal_x) && $stable(out_normal_z))
    else $error("result changed while stalled");

  a_frame_run: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_frame_end |-> out_run_end)
    else $error("frame end without run end");

  a_reset_quiet: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result valid right after reset");
endmodule

bind hex_grid_heightmap_normals hgn_checker u_hgn_checker (
  .clk(clk), .rst(rst), .out_valid(normals.valid), .out_ready(normals.ready),
  .out_normal_x(normals.normal_x), .out_normal_z(normals.normal_z),
  .out_run_end(normals.run_end), .out_frame_end(normals.frame_end)
);
`default_nettype wire
